// File: rtl/core/uart4x_pkg.sv
// Shared codes and types for the 4x oversampled UART transceiver.
package uart4x_pkg;

    typedef logic [1:0] t_kind;
    typedef logic [1:0] t_status;
    typedef logic [5:0] t_phase;

    localparam t_kind KIND_TICK = 2'd0;
    localparam t_kind KIND_PUSH = 2'd1;
    localparam t_kind KIND_POP  = 2'd2;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_TX_FULL  = 2'd1;
    localparam t_status ST_RX_EMPTY = 2'd2;

    localparam t_phase LAST_PHASE = 6'd39;
    localparam int     FILL_W     = 5;
    localparam int     FRAME_BITS = 10;

endpackage

// File: rtl/core/uart_transceiver_4x_oversample.sv
// 8N1 UART transceiver with 4x oversampling and transmit/receive FIFOs.
// One request is taken per cycle unless both stages are full and stalled. Each
// request (tick, push or pop) updates the line machines and FIFO pointers in the
// cycle it is accepted; its result passes a stage that captures the FIFO read
// data and then an output register. Throughput is one request per cycle whenever the
// result side takes results; a waiting result still lets one more request in.
// The FIFO stores are memories with registered reads and are not cleared after
// reset; only entries that the fill counts mark as written reach the outputs.
module uart_transceiver_4x_oversample
    import uart4x_pkg::*;
#(
    parameter int TX_DEPTH = 16,
    parameter int RX_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic        i_rx_line,
    input  logic [7:0]  i_write_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_tx_line,
    output logic [7:0]  o_read_byte,
    output logic [1:0]  o_status,
    output logic [4:0]  o_tx_fill,
    output logic [4:0]  o_rx_fill
);

    localparam int TXP_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int RXP_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int TXC_W = $clog2(TX_DEPTH + 1);
    localparam int RXC_W = $clog2(RX_DEPTH + 1);

    localparam logic [TXP_W-1:0] TX_LAST_IDX = TXP_W'(TX_DEPTH - 1);
    localparam logic [RXP_W-1:0] RX_LAST_IDX = RXP_W'(RX_DEPTH - 1);
    localparam logic [TXC_W-1:0] TX_FULL_CNT = TXC_W'(TX_DEPTH);
    localparam logic [RXC_W-1:0] RX_FULL_CNT = RXC_W'(RX_DEPTH);

    logic [7:0] r_tx_mem [TX_DEPTH];
    logic [7:0] r_rx_mem [RX_DEPTH];

    logic             r_tx_busy, n_tx_busy;
    t_phase           r_tx_phase, n_tx_phase;
    logic [7:0]       r_tx_data;
    logic             r_tx_level, n_tx_level;
    logic [TXP_W-1:0] r_tx_head, n_tx_head;
    logic [TXP_W-1:0] r_tx_tail, n_tx_tail;
    logic [TXC_W-1:0] r_tx_count, n_tx_count;

    logic                  r_rx_busy, n_rx_busy;
    t_phase                r_rx_phase, n_rx_phase;
    logic [FRAME_BITS-1:0] r_rx_shift, n_rx_shift;
    logic [RXP_W-1:0]      r_rx_head, n_rx_head;
    logic [RXP_W-1:0]      r_rx_tail, n_rx_tail;
    logic [RXC_W-1:0]      r_rx_count, n_rx_count;

    logic    w_tx_wr, w_tx_load, w_rx_wr, w_pop_ok;
    t_status w_status;
    logic    w_tx_bit;
    logic [3:0] w_bit_idx;

    logic       r_s1_valid, r_s1_tx_line, r_s1_pop_ok;
    logic [7:0] r_s1_byte;
    t_status    r_s1_status;
    logic [4:0] r_s1_tx_fill, r_s1_rx_fill;

    logic       r_out_valid, r_out_tx_line;
    logic [7:0] r_out_byte;
    t_status    r_out_status;
    logic [4:0] r_out_tx_fill, r_out_rx_fill;

    logic w_s1_move, w_accept;

    assign w_s1_move = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_s1_valid || w_s1_move;
    assign w_accept  = i_valid && o_ready;

    assign w_bit_idx = r_tx_phase[5:2];

    always_comb begin
        if (w_bit_idx == 4'd0) begin
            w_tx_bit = 1'b0;
        end else if (w_bit_idx >= 4'd9) begin
            w_tx_bit = 1'b1;
        end else begin
            w_tx_bit = r_tx_data[3'(w_bit_idx - 4'd1)];
        end
    end

    always_comb begin
        n_tx_busy  = r_tx_busy;
        n_tx_phase = r_tx_phase;
        n_tx_level = r_tx_level;
        n_tx_head  = r_tx_head;
        n_tx_tail  = r_tx_tail;
        n_tx_count = r_tx_count;
        n_rx_busy  = r_rx_busy;
        n_rx_phase = r_rx_phase;
        n_rx_shift = r_rx_shift;
        n_rx_head  = r_rx_head;
        n_rx_tail  = r_rx_tail;
        n_rx_count = r_rx_count;
        w_tx_wr    = 1'b0;
        w_tx_load  = 1'b0;
        w_rx_wr    = 1'b0;
        w_pop_ok   = 1'b0;
        w_status   = ST_OK;

        unique case (i_kind)
            KIND_TICK: begin
                if (!r_tx_busy) begin
                    if (r_tx_count != '0) begin
                        n_tx_phase = '0;
                        n_tx_busy  = 1'b1;
                        w_tx_load  = 1'b1;
                    end
                end else begin
                    if (r_tx_phase >= LAST_PHASE) begin
                        n_tx_head  = (r_tx_head == TX_LAST_IDX) ? '0 : r_tx_head + 1'b1;
                        n_tx_count = (r_tx_count != '0) ? r_tx_count - 1'b1 : r_tx_count;
                        n_tx_level = 1'b1;
                        n_tx_busy  = 1'b0;
                    end else if (r_tx_phase[1:0] == 2'd0) begin
                        n_tx_level = w_tx_bit;
                    end
                    n_tx_phase = r_tx_phase + 1'b1;
                end

                if (!r_rx_busy) begin
                    if (!i_rx_line) begin
                        n_rx_phase = 6'd1;
                        n_rx_shift = '0;
                        n_rx_busy  = 1'b1;
                    end
                end else begin
                    if (r_rx_phase >= LAST_PHASE) begin
                        if (!r_rx_shift[0] && r_rx_shift[FRAME_BITS-1]
                            && (r_rx_count < RX_FULL_CNT)) begin
                            w_rx_wr    = 1'b1;
                            n_rx_tail  = (r_rx_tail == RX_LAST_IDX) ? '0 : r_rx_tail + 1'b1;
                            n_rx_count = r_rx_count + 1'b1;
                        end
                        n_rx_busy = 1'b0;
                    end else if (r_rx_phase[1:0] == 2'd2) begin
                        n_rx_shift = {i_rx_line, r_rx_shift[FRAME_BITS-1:1]};
                    end
                    n_rx_phase = r_rx_phase + 1'b1;
                end
            end
            KIND_PUSH: begin
                if (r_tx_count >= TX_FULL_CNT) begin
                    w_status = ST_TX_FULL;
                end else begin
                    w_tx_wr    = 1'b1;
                    n_tx_tail  = (r_tx_tail == TX_LAST_IDX) ? '0 : r_tx_tail + 1'b1;
                    n_tx_count = r_tx_count + 1'b1;
                end
            end
            KIND_POP: begin
                if (r_rx_count == '0) begin
                    w_status = ST_RX_EMPTY;
                end else begin
                    w_pop_ok   = 1'b1;
                    n_rx_head  = (r_rx_head == RX_LAST_IDX) ? '0 : r_rx_head + 1'b1;
                    n_rx_count = r_rx_count - 1'b1;
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_busy  <= 1'b0;
            r_tx_phase <= '0;
            r_tx_level <= 1'b1;
            r_tx_head  <= '0;
            r_tx_tail  <= '0;
            r_tx_count <= '0;
            r_rx_busy  <= 1'b0;
            r_rx_phase <= '0;
            r_rx_shift <= '0;
            r_rx_head  <= '0;
            r_rx_tail  <= '0;
            r_rx_count <= '0;
        end else if (w_accept) begin
            r_tx_busy  <= n_tx_busy;
            r_tx_phase <= n_tx_phase;
            r_tx_level <= n_tx_level;
            r_tx_head  <= n_tx_head;
            r_tx_tail  <= n_tx_tail;
            r_tx_count <= n_tx_count;
            r_rx_busy  <= n_rx_busy;
            r_rx_phase <= n_rx_phase;
            r_rx_shift <= n_rx_shift;
            r_rx_head  <= n_rx_head;
            r_rx_tail  <= n_rx_tail;
            r_rx_count <= n_rx_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_tx_wr) begin
            r_tx_mem[r_tx_tail] <= i_write_byte;
        end
        if (w_accept && w_tx_load) begin
            r_tx_data <= r_tx_mem[r_tx_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_rx_wr) begin
            r_rx_mem[r_rx_tail] <= r_rx_shift[8:1];
        end
        if (w_accept) begin
            r_s1_byte <= r_rx_mem[r_rx_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_tx_line <= n_tx_level;
            r_s1_pop_ok  <= w_pop_ok;
            r_s1_status  <= w_status;
            r_s1_tx_fill <= FILL_W'(n_tx_count);
            r_s1_rx_fill <= FILL_W'(n_rx_count);
        end
        if (w_s1_move) begin
            r_out_tx_line <= r_s1_tx_line;
            r_out_byte    <= r_s1_pop_ok ? r_s1_byte : 8'd0;
            r_out_status  <= r_s1_status;
            r_out_tx_fill <= r_s1_tx_fill;
            r_out_rx_fill <= r_s1_rx_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_tx_line   = r_out_tx_line;
    assign o_read_byte = r_out_byte;
    assign o_status    = r_out_status;
    assign o_tx_fill   = r_out_tx_fill;
    assign o_rx_fill   = r_out_rx_fill;

`ifndef SYNTHESIS
    a_tx_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_count <= TX_FULL_CNT)
        else $error("transmit count above depth");

    a_rx_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rx_count <= RX_FULL_CNT)
        else $error("receive count above depth");

    a_tx_idle_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_tx_busy |-> r_tx_level)
        else $error("transmit line low while idle");

    a_tx_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_busy |-> (r_tx_phase <= LAST_PHASE) && (r_tx_count != '0))
        else $error("transmit phase or count inconsistent while busy");

    a_rx_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rx_busy |-> (r_rx_phase != '0) && (r_rx_phase <= LAST_PHASE))
        else $error("receive phase out of range while busy");

    a_pop_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_read_byte == 8'd0))
        else $error("refused request returned data");
`endif

endmodule

// File: sim/tb.sv
// Self-checking testbench for the 4x oversampled UART transceiver with FIFOs.
module tb
    import uart4x_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     TXQ_DEPTH   = 16;
    localparam int     RXQ_DEPTH   = 16;
    localparam int     CYCLE_LIMIT = 200000;
    localparam int     MAX_REPORTS = 10;
    localparam t_kind  KIND_NONE   = 2'd3;

    typedef struct packed {
        logic       tx_line;
        logic [7:0] read_byte;
        t_status    status;
        logic [4:0] tx_fill;
        logic [4:0] rx_fill;
    } t_uart_out;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic [1:0] i_kind       = KIND_TICK;
    logic       i_rx_line    = 1'b1;
    logic [7:0] i_write_byte = 8'h00;
    logic       i_ready      = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic       o_tx_line;
    logic [7:0] o_read_byte;
    logic [1:0] o_status;
    logic [4:0] o_tx_fill;
    logic [4:0] o_rx_fill;

    uart_transceiver_4x_oversample #(
        .TX_DEPTH(TXQ_DEPTH),
        .RX_DEPTH(RXQ_DEPTH)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_kind      (i_kind),
        .i_rx_line   (i_rx_line),
        .i_write_byte(i_write_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_tx_line   (o_tx_line),
        .o_read_byte (o_read_byte),
        .o_status    (o_status),
        .o_tx_fill   (o_tx_fill),
        .o_rx_fill   (o_rx_fill)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predicted line machines and FIFOs
    logic       ser_busy;
    t_phase     ser_phase;
    logic [9:0] ser_frame;
    logic       line_lvl;
    logic [7:0] txq_mem [TXQ_DEPTH];
    int         txq_rd, txq_wr, txq_cnt;
    logic       des_busy;
    t_phase     des_phase;
    logic [9:0] des_frame;
    logic [7:0] rxq_mem [RXQ_DEPTH];
    int         rxq_rd, rxq_wr, rxq_cnt;

    t_uart_out uart_out_q[$];

    int idle_pct       = 0;
    int stall_pct      = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;
    int frames_kept    = 0;
    int frames_dropped = 0;
    int bytes_sent     = 0;
    int full_pushes    = 0;
    int empty_pops     = 0;

    function automatic void reset_uart_model();
        ser_busy  = 1'b0;
        ser_phase = '0;
        ser_frame = '0;
        line_lvl  = 1'b1;
        txq_rd    = 0;
        txq_wr    = 0;
        txq_cnt   = 0;
        des_busy  = 1'b0;
        des_phase = '0;
        des_frame = '0;
        rxq_rd    = 0;
        rxq_wr    = 0;
        rxq_cnt   = 0;
    endfunction

    function automatic void serializer_tick();
        if (!ser_busy) begin
            if (txq_cnt > 0) begin
                ser_phase = '0;
                ser_frame = {1'b1, txq_mem[txq_rd], 1'b0};
                ser_busy  = 1'b1;
            end
            return;
        end
        if (ser_phase >= LAST_PHASE) begin
            txq_rd = (txq_rd + 1) % TXQ_DEPTH;
            if (txq_cnt > 0) txq_cnt--;
            line_lvl = 1'b1;
            ser_busy = 1'b0;
            bytes_sent++;
        end else if (ser_phase[1:0] == 2'd0) begin
            line_lvl  = ser_frame[0];
            ser_frame = ser_frame >> 1;
        end
        ser_phase = ser_phase + 6'd1;
    endfunction

    function automatic void deserializer_tick(input logic line);
        if (!des_busy) begin
            if (!line) begin
                des_phase = 6'd1;
                des_frame = '0;
                des_busy  = 1'b1;
            end
            return;
        end
        if (des_phase >= LAST_PHASE) begin
            if (!des_frame[0] && des_frame[FRAME_BITS-1] && rxq_cnt < RXQ_DEPTH) begin
                rxq_mem[rxq_wr] = des_frame[8:1];
                rxq_wr = (rxq_wr + 1) % RXQ_DEPTH;
                rxq_cnt++;
                frames_kept++;
            end else begin
                frames_dropped++;
            end
            des_busy = 1'b0;
        end else if (des_phase[1:0] == 2'd2) begin
            des_frame = {line, des_frame[FRAME_BITS-1:1]};
        end
        des_phase = des_phase + 6'd1;
    endfunction

    function automatic t_uart_out uart_step(input t_kind kind, input logic line,
                                            input logic [7:0] wbyte);
        t_uart_out res;
        res = '0;
        res.status = ST_OK;
        case (kind)
            KIND_TICK: begin
                serializer_tick();
                deserializer_tick(line);
            end
            KIND_PUSH: begin
                if (txq_cnt >= TXQ_DEPTH) begin
                    res.status = ST_TX_FULL;
                    full_pushes++;
                end else begin
                    txq_mem[txq_wr] = wbyte;
                    txq_wr = (txq_wr + 1) % TXQ_DEPTH;
                    txq_cnt++;
                end
            end
            KIND_POP: begin
                if (rxq_cnt == 0) begin
                    res.status = ST_RX_EMPTY;
                    empty_pops++;
                end else begin
                    res.read_byte = rxq_mem[rxq_rd];
                    rxq_rd = (rxq_rd + 1) % RXQ_DEPTH;
                    rxq_cnt--;
                end
            end
            default: ;
        endcase
        res.tx_line = line_lvl;
        res.tx_fill = 5'(txq_cnt);
        res.rx_fill = 5'(rxq_cnt);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] seen);
        if (seen !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("[%0t] %s mismatch: expected %0h, got %0h", $realtime, name, want, seen);
        end
    endtask

    task automatic compare_out(input t_uart_out want, input t_uart_out seen);
        check_field("tx_line", 8'(want.tx_line), 8'(seen.tx_line));
        check_field("read_byte", want.read_byte, seen.read_byte);
        check_field("status", 8'(want.status), 8'(seen.status));
        check_field("tx_fill", 8'(want.tx_fill), 8'(seen.tx_fill));
        check_field("rx_fill", 8'(want.rx_fill), 8'(seen.rx_fill));
    endtask

    always @(posedge i_clk) begin
        t_uart_out seen;
        if (i_rst_n) begin
            if (i_valid && o_ready)
                uart_out_q.push_back(uart_step(i_kind, i_rx_line, i_write_byte));
            if (o_valid && i_ready) begin
                seen = {o_tx_line, o_read_byte, o_status, o_tx_fill, o_rx_fill};
                results_seen++;
                if (uart_out_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("[%0t] result with no request pending: %h", $realtime, seen);
                end else begin
                    compare_out(uart_out_q.pop_front(), seen);
                end
            end
        end
    end

    always @(negedge i_clk)
        i_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    // enter and leave at a falling edge
    task automatic send_item(input t_kind kind, input logic line, input logic [7:0] wbyte);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_kind       <= kind;
        i_rx_line    <= line;
        i_write_byte <= wbyte;
        do @(posedge i_clk); while (!o_ready);
        if (kind != KIND_NONE) items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        while (uart_out_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic send_side_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50)
            send_item(KIND_PUSH, 1'($urandom_range(1)), 8'($urandom_range(255)));
        else if (pick < 95)
            send_item(KIND_POP, 1'($urandom_range(1)), 8'($urandom_range(255)));
        else
            send_item(KIND_NONE, 1'($urandom_range(1)), 8'($urandom_range(255)));
    endtask

    task automatic send_frame(input logic [7:0] data, input logic glitch, input logic stop_lvl);
        logic [9:0] bits;
        logic       lvl;
        bits = {stop_lvl, data, 1'b0};
        while (des_busy) send_item(KIND_TICK, 1'b1, 8'($urandom_range(255)));
        for (int b = 0; b < FRAME_BITS; b++) begin
            for (int t = 0; t < 4; t++) begin
                if ($urandom_range(99) < 10) send_side_item();
                lvl = (b == 0 && t > 0 && glitch) ? 1'b1 : bits[b];
                send_item(KIND_TICK, lvl, 8'($urandom_range(255)));
            end
        end
        repeat ($urandom_range(3)) send_item(KIND_TICK, 1'b1, 8'($urandom_range(255)));
    endtask

    task automatic send_loopback();
        while (ser_busy || txq_cnt != 0)
            send_item(KIND_TICK, line_lvl, 8'($urandom_range(255)));
        repeat (45) send_item(KIND_TICK, line_lvl, 8'($urandom_range(255)));
    endtask

    task automatic test_directed();
        idle_pct  = 0;
        stall_pct = 0;
        send_item(KIND_POP, 1'b0, 8'hFF);
        send_item(KIND_NONE, 1'b0, 8'hFF);
        send_item(KIND_PUSH, 1'b0, 8'h00);
        send_item(KIND_PUSH, 1'b1, 8'hFF);
        send_item(KIND_PUSH, 1'b0, 8'h5A);
        send_item(KIND_NONE, 1'b1, 8'h00);
        repeat (3) send_item(KIND_TICK, 1'b1, 8'hFF);
        send_item(KIND_TICK, 1'b0, 8'h00);
        for (int i = 0; i < 6; i++) send_item(KIND_TICK, 1'(i), 8'hAA);
        send_item(KIND_POP, 1'b1, 8'h00);
        send_item(KIND_PUSH, 1'b1, 8'hA5);
        send_item(KIND_NONE, 1'b0, 8'h00);
        send_item(KIND_TICK, 1'b1, 8'h55);
        wait_drain();
    endtask

    task automatic test_fifo_limits();
        idle_pct  = 0;
        stall_pct = 0;
        while (ser_busy || txq_cnt != 0 || des_busy) send_item(KIND_TICK, 1'b1, 8'h00);
        while (rxq_cnt != 0) send_item(KIND_POP, 1'b1, 8'h00);
        while (txq_cnt < TXQ_DEPTH) send_item(KIND_PUSH, 1'b1, 8'($urandom_range(255)));
        send_item(KIND_PUSH, 1'b0, 8'hFF);
        send_loopback();
        // receive side is full now, so this frame is lost
        send_item(KIND_PUSH, 1'b1, 8'hC3);
        send_loopback();
        repeat (RXQ_DEPTH + 1) send_item(KIND_POP, 1'b0, 8'h00);
        wait_drain();
    endtask

    task automatic test_random(input int idle, input int stall, input int target);
        int first;
        int pick;
        idle_pct  = idle;
        stall_pct = stall;
        first     = items_sent;
        while (items_sent - first < target) begin
            pick = $urandom_range(99);
            if (pick < 60)
                send_frame(8'($urandom_range(255)), 1'b0, 1'b1);
            else if (pick < 68)
                send_frame(8'($urandom_range(255)), 1'b0, 1'b0);
            else if (pick < 76)
                send_frame(8'($urandom_range(255)), 1'b1, 1'b1);
            else if (pick < 88)
                repeat ($urandom_range(20, 8))
                    send_item(t_kind'($urandom_range(3)), 1'($urandom_range(1)),
                              8'($urandom_range(255)));
            else
                repeat ($urandom_range(6, 1)) send_side_item();
        end
        wait_drain();
    endtask

    initial begin
        reset_uart_model();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_fifo_limits();
        test_random(0, 0, 150);
        test_random(60, 0, 150);
        test_random(0, 60, 150);
        test_random(26, 26, 150);
        wait_drain();
        repeat (16) @(negedge i_clk);
        $display("%0d requests, %0d results checked; %0d bytes sent on the line",
                 items_sent, results_seen, bytes_sent);
        $display("%0d frames kept, %0d dropped, %0d pushes when full, %0d pops when empty",
                 frames_kept, frames_dropped, full_pushes, empty_pops);
        if (mismatch_count == 0 && uart_out_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_count, uart_out_q.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/uart4x_pkg.sv
rtl/core/uart_transceiver_4x_oversample.sv
sim/tb.sv
